### rtl/assert_macros.svh
// Assertion macros used by the decoder top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### rtl/lhsc_pkg.sv
// Types, constants and the arctangent table of the hall angle decoder
package lhsc_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int FIX_W     = 15;
  localparam int NORM_W    = 17;
  localparam int NORM_FRAC = 15;
  localparam int CORD_W    = 27;
  localparam int ANGLE_W   = 16;
  localparam int ACC_W     = 32;
  localparam int IDX_W     = 5;

  localparam logic [FIX_W-1:0] MIN_A_RST = 15'd1288;
  localparam logic [FIX_W-1:0] MAX_A_RST = 15'd32736;
  localparam logic [FIX_W-1:0] MIN_B_RST = 15'd1288;
  localparam logic [FIX_W-1:0] MAX_B_RST = 15'd32752;

  localparam logic DIV_NORM_A = 1'b0;
  localparam logic DIV_NORM_B = 1'b1;

  typedef struct packed {
    logic capture;
    logic sum_upd;
    logic avg_load;
    logic div_load;
    logic div_step;
    logic div_sel;
    logic track;
    logic cor_load;
    logic cor_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic cor_last;
  } status_t;

  function automatic logic [ACC_W-1:0] atan_turn(input logic [IDX_W-1:0] i);
    logic [ACC_W-1:0] r;
    case (i)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/linear_hall_sincos_angle_decoder_core.sv
// Top level of the linear hall sin/cos angle decoder
//
// Each input transfer carries one pair of 12-bit hall samples (sine on A,
// cosine on B) and an opcode that also widens the min/max calibration when
// set. The pair enters a moving-average window of FILTER_DEPTH pairs held in
// a small RAM, each channel is normalised against its tracked span to Q2.15
// and a vectoring CORDIC of CORDIC_STEPS steps gives a 16-bit full-turn
// angle; a zero or negative span sets the degenerate flag with angle zero.
// One item is processed at a time, and the next pair is accepted from the
// cycle after the result is stored. The time is set by one shared bit-serial
// divider (two 15-step normalisations) and the iterative CORDIC; the window
// averages come from a constant reciprocal multiply. The result waits in an
// output register, and a result the receiver has not yet taken holds the
// block before it stores the next one.
`include "assert_macros.svh"

module linear_hall_sincos_angle_decoder_core #(
  parameter int FILTER_DEPTH = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // sample_a [11:0], sample_b [23:12]
  input  logic        s_tuser,   // opcode [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // angle [15:0]
  output logic        m_tuser    // degenerate [0]
);

  lhsc_pkg::cmd_t    cmd;
  lhsc_pkg::status_t status;

  lhsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lhsc_dp #(
    .FILTER_DEPTH (FILTER_DEPTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_data    (s_tdata),
    .in_op      (s_tuser),
    .angle      (m_tdata),
    .degenerate (m_tuser)
  );

  `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid))
  `ASSERT_ALWAYS(a_degenerate_zero_angle, !(m_tvalid && m_tuser) || m_tdata == 16'd0)

endmodule

### rtl/lhsc_ram.sv
// Generic single-port-write RAM with registered read
module lhsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/lhsc_dp.sv
// Datapath: averaging window, min/max trackers, shared divider, CORDIC
module lhsc_dp #(
  parameter int FILTER_DEPTH = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lhsc_pkg::cmd_t                  cmd,
  output lhsc_pkg::status_t               status,
  input  logic [2*lhsc_pkg::SAMPLE_W-1:0] in_data,
  input  logic                            in_op,
  output logic [lhsc_pkg::ANGLE_W-1:0]    angle,
  output logic                            degenerate
);

  localparam int PW   = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int SUMW = $clog2(4096 * FILTER_DEPTH);
  localparam int NW   = SUMW + 3;
  localparam int RL   = $clog2(FILTER_DEPTH);
  localparam int RK   = NW + RL;
  localparam int MW   = NW + 2;
  localparam int PRW  = NW + MW;
  localparam int CW   = $clog2(lhsc_pkg::NORM_FRAC + 1);
  localparam int SW   = lhsc_pkg::SAMPLE_W;
  localparam int FW   = lhsc_pkg::FIX_W;
  localparam int XW   = lhsc_pkg::CORD_W;
  localparam int AW   = lhsc_pkg::ACC_W;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << RK) + 64'(FILTER_DEPTH - 1)) / 64'(FILTER_DEPTH));

  logic                    op;
  logic [SW-1:0]           in_a, in_b;
  logic [PW-1:0]           ptr;
  logic [FILTER_DEPTH-1:0] valid;
  logic [2*SW-1:0]         rdata;
  logic [2*SW-1:0]         old;
  logic [SUMW-1:0]         sum_a, sum_b;
  logic [FW-1:0]           avg_a, avg_b;
  logic [FW-1:0]           min_a, max_a, min_b, max_b;
  logic [PRW-1:0]          prod_a, prod_b;

  lhsc_ram #(.WIDTH(2*SW), .DEPTH(FILTER_DEPTH)) u_window (
    .clk   (clk),
    .we    (cmd.sum_upd),
    .waddr (ptr),
    .wdata ({in_b, in_a}),
    .re    (cmd.capture),
    .raddr (ptr),
    .rdata (rdata)
  );

  assign old = valid[ptr] ? rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= in_op;
      in_a <= in_data[SW-1:0];
      in_b <= in_data[2*SW-1:SW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      valid <= '0;
      sum_a <= '0;
      sum_b <= '0;
    end else if (cmd.sum_upd) begin
      valid[ptr] <= 1'b1;
      ptr        <= (ptr == PW'(FILTER_DEPTH - 1)) ? '0 : ptr + 1'b1;
      sum_a      <= sum_a - SUMW'(old[SW-1:0]) + SUMW'(in_a);
      sum_b      <= sum_b - SUMW'(old[2*SW-1:SW]) + SUMW'(in_b);
    end
  end

  // window average: multiply by the reciprocal of the depth
  assign prod_a = PRW'({sum_a, 3'b000}) * PRW'(RECIP);
  assign prod_b = PRW'({sum_b, 3'b000}) * PRW'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.avg_load) begin
      avg_a <= prod_a[RK +: FW];
      avg_b <= prod_b[RK +: FW];
    end
  end

  // normalisation operands for the channel selected by the divider
  logic          sel_b;
  logic [FW-1:0] n_avg, n_lo, n_hi;
  logic [15:0]   span;
  logic [16:0]   hl_sum;
  logic [17:0]   diff, diff_abs;
  logic          n_bad, n_neg, n_sat;

  assign sel_b    = (cmd.div_sel == lhsc_pkg::DIV_NORM_B);
  assign n_avg    = sel_b ? avg_b : avg_a;
  assign n_lo     = sel_b ? min_b : min_a;
  assign n_hi     = sel_b ? max_b : max_a;
  assign span     = {1'b0, n_hi} - {1'b0, n_lo};
  assign n_bad    = span[15] || (span == 16'd0);
  assign hl_sum   = {2'b0, n_hi} + {2'b0, n_lo};
  assign diff     = {2'b0, n_avg, 1'b0} - {1'b0, hl_sum};
  assign n_neg    = diff[17];
  assign diff_abs = n_neg ? -diff : diff;
  assign n_sat    = n_bad || (diff_abs >= {2'b0, span});

  // shared restoring divider
  logic [15:0]   rem;
  logic [15:0]   den;
  logic [FW-1:0] quo, quo_next;
  logic [CW-1:0] cnt;
  logic [16:0]   trial;
  logic          ge;
  logic          neg, sat, bad_a, bad_b;
  logic [lhsc_pkg::NORM_W-1:0] qmag, qval, na, nb;

  assign trial    = {rem, 1'b0};
  assign ge       = trial >= {1'b0, den};
  assign quo_next = {quo[FW-2:0], ge};
  assign qmag     = sat ? 17'd32768 : {2'b0, quo_next};
  assign qval     = neg ? -qmag : qmag;
  assign status.div_last = (cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo <= '0;
      rem <= n_sat ? 16'd0 : diff_abs[15:0];
      den <= n_bad ? 16'd1 : span;
      cnt <= CW'(lhsc_pkg::NORM_FRAC);
      neg <= n_neg;
      sat <= n_sat;
      if (sel_b) begin
        bad_b <= n_bad;
      end else begin
        bad_a <= n_bad;
      end
    end else if (cmd.div_step) begin
      rem <= ge ? 16'(trial - {1'b0, den}) : trial[15:0];
      quo <= quo_next;
      cnt <= cnt - 1'b1;
      if (status.div_last) begin
        if (sel_b) begin
          nb <= qval;
        end else begin
          na <= qval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_a <= lhsc_pkg::MIN_A_RST;
      max_a <= lhsc_pkg::MAX_A_RST;
      min_b <= lhsc_pkg::MIN_B_RST;
      max_b <= lhsc_pkg::MAX_B_RST;
    end else if (cmd.track && op) begin
      if (avg_a < min_a) min_a <= avg_a;
      if (avg_a > max_a) max_a <= avg_a;
      if (avg_b < min_b) min_b <= avg_b;
      if (avg_b > max_b) max_b <= avg_b;
    end
  end

  // vectoring CORDIC
  logic signed [XW-1:0] x, y, x0, y0, xs, ys;
  logic [AW-1:0]        acc;
  logic [lhsc_pkg::IDX_W-1:0] idx;
  logic                 zero;
  logic                 y_pos;
  logic [AW-1:0]        acc_rnd;

  assign x0      = {{2{nb[16]}}, nb, 8'b0};
  assign y0      = {{2{na[16]}}, na, 8'b0};
  assign xs      = x >>> idx;
  assign ys      = y >>> idx;
  assign y_pos   = !y[XW-1] && (y != '0);
  assign acc_rnd = acc + 32'h0000_8000;
  assign status.cor_last = (idx == lhsc_pkg::IDX_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.cor_load) begin
      zero <= (na == '0) && (nb == '0);
      idx  <= '0;
      if (x0[XW-1]) begin
        x   <= -x0;
        y   <= -y0;
        acc <= 32'h8000_0000;
      end else begin
        x   <= x0;
        y   <= y0;
        acc <= '0;
      end
    end else if (cmd.cor_step) begin
      idx <= idx + 1'b1;
      if (y_pos) begin
        x   <= x + ys;
        y   <= y - xs;
        acc <= acc + lhsc_pkg::atan_turn(idx);
      end else begin
        x   <= x - ys;
        y   <= y + xs;
        acc <= acc - lhsc_pkg::atan_turn(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      degenerate <= bad_a || bad_b;
      angle      <= (bad_a || bad_b || zero) ? '0 : acc_rnd[AW-1:AW-lhsc_pkg::ANGLE_W];
    end
  end

endmodule

### rtl/lhsc_ctrl.sv
// Controller: sequences window update, divisions, tracking and CORDIC
module lhsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  lhsc_pkg::status_t status,
  output lhsc_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_UPDATE = 4'd1;
  localparam logic [3:0] ST_AVG    = 4'd2;
  localparam logic [3:0] ST_TRACK  = 4'd3;
  localparam logic [3:0] ST_DLOAD  = 4'd4;
  localparam logic [3:0] ST_DRUN   = 4'd5;
  localparam logic [3:0] ST_CLOAD  = 4'd6;
  localparam logic [3:0] ST_CRUN   = 4'd7;
  localparam logic [3:0] ST_FINISH = 4'd8;

  logic [3:0] state, state_next;
  logic       sel, sel_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next  = state;
    sel_next    = sel;
    cmd         = '0;
    cmd.div_sel = sel;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.sum_upd = 1'b1;
        state_next  = ST_AVG;
      end
      ST_AVG: begin
        cmd.avg_load = 1'b1;
        state_next   = ST_TRACK;
      end
      ST_TRACK: begin
        cmd.track  = 1'b1;
        sel_next   = lhsc_pkg::DIV_NORM_A;
        state_next = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DRUN;
      end
      ST_DRUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          if (sel == lhsc_pkg::DIV_NORM_B) begin
            state_next = ST_CLOAD;
          end else begin
            sel_next   = lhsc_pkg::DIV_NORM_B;
            state_next = ST_DLOAD;
          end
        end
      end
      ST_CLOAD: begin
        cmd.cor_load = 1'b1;
        state_next   = ST_CRUN;
      end
      ST_CRUN: begin
        cmd.cor_step = 1'b1;
        if (status.cor_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sel      <= lhsc_pkg::DIV_NORM_A;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
